// ===== design/ita_pkg.sv =====
// ----------------------------------------------------------------------------
// ita_pkg
// Shared types, character codes and lookup functions for the integer to
// ASCII formatter.
// ----------------------------------------------------------------------------
package ita_pkg;

  typedef enum logic [2:0] {
    OP_SDEC = 3'd0,
    OP_UDEC = 3'd1,
    OP_HEXL = 3'd2,
    OP_HEXU = 3'd3,
    OP_PTR  = 3'd4
  } ita_op_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CONV,
    ST_EMIT
  } ita_state_t;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX,
    PFX_NIL
  } ita_pfx_t;

  // control from the sequencer to the shared divide unit
  typedef struct packed {
    logic load;
    logic step;
    logic dec;
  } ita_unit_ctl_t;

  // one character beat from the sequencer to the output stage
  typedef struct packed {
    logic       valid;
    logic [7:0] code;
    logic       last;
  } ita_char_beat_t;

  // floor(x / 10) == (x * RECIP10) >> 35 for any 32-bit x
  localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int          RECIP_SHIFT = 35;

  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_I      = 8'h69;
  localparam logic [7:0] CH_L      = 8'h6C;
  localparam logic [7:0] CH_A_LO   = 8'h61;
  localparam logic [7:0] CH_A_UP   = 8'h41;

  function automatic logic [2:0] pfx_len(input ita_pfx_t p);
    case (p)
      PFX_MINUS: pfx_len = 3'd1;
      PFX_HEX:   pfx_len = 3'd2;
      PFX_NIL:   pfx_len = 3'd5;
      default:   pfx_len = 3'd0;
    endcase
  endfunction

  function automatic logic [7:0] pfx_char(input ita_pfx_t p, input logic [2:0] pos);
    logic [7:0] c;
    c = CH_MINUS;
    case (p)
      PFX_HEX: c = (pos == 3'd0) ? CH_ZERO : CH_X;
      PFX_NIL: begin
        case (pos)
          3'd0:    c = CH_LPAREN;
          3'd1:    c = CH_N;
          3'd2:    c = CH_I;
          3'd3:    c = CH_L;
          default: c = CH_RPAREN;
        endcase
      end
      default: c = CH_MINUS;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else if (upper) begin
      c = CH_A_UP + {4'd0, d - 4'd10};
    end else begin
      c = CH_A_LO + {4'd0, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== design/ita_in_if.sv =====
// ----------------------------------------------------------------------------
// ita_in_if
// Input channel: one conversion request per beat.
// ----------------------------------------------------------------------------
interface ita_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [63:0] value;

  modport source (output valid, output op, output value, input ready);
  modport sink   (input valid, input op, input value, output ready);
endinterface

// ===== design/ita_out_if.sv =====
// ----------------------------------------------------------------------------
// ita_out_if
// Output channel: one ASCII character per beat.
// ----------------------------------------------------------------------------
interface ita_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  char_code;
  logic        last_char;
  logic [31:0] total_emitted;

  modport source (output valid, output char_code, output last_char, output total_emitted,
                  input ready);
  modport sink   (input valid, input char_code, input last_char, input total_emitted,
                  output ready);
endinterface

// ===== design/ita_digit_unit.sv =====
// ----------------------------------------------------------------------------
// ita_digit_unit
// Shared divide-by-base unit. Each step splits off one digit (base 10 by
// reciprocal multiply, base 16 by shift) and writes it to the digit store.
// The store is read through a registered port: rd_addr is the address of the
// digit wanted in the next cycle.
// ----------------------------------------------------------------------------
module ita_digit_unit
  import ita_pkg::*;
#(
  parameter int DIGIT_SLOTS = 16,
  localparam int AW = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1,
  localparam int CW = $clog2(DIGIT_SLOTS + 1)
) (
  input  logic          clk,
  input  logic          rst,
  input  ita_unit_ctl_t ctl,
  input  logic [63:0]   load_val,
  input  logic [AW-1:0] rd_addr,
  output logic [3:0]    rd_digit,
  output logic [CW-1:0] count,
  output logic          last_step
);

  logic [63:0] mag;
  logic        dec;
  logic [3:0]  store [DIGIT_SLOTS];
  logic [63:0] prod;
  logic [63:0] quo_dec;
  logic [63:0] quo;
  logic [3:0]  tenq;
  logic [3:0]  digit;

  always_comb begin
    prod    = {32'd0, mag[31:0]} * {32'd0, RECIP10};
    quo_dec = {{RECIP_SHIFT{1'b0}}, prod[63:RECIP_SHIFT]};
    // only the low nibble of 10*q matters: the remainder is below 10
    tenq    = {quo_dec[0], 3'b000} + {quo_dec[2:0], 1'b0};
    if (dec) begin
      quo   = quo_dec;
      digit = mag[3:0] - tenq;
    end else begin
      quo   = {4'd0, mag[63:4]};
      digit = mag[3:0];
    end
    last_step = (quo == 64'd0) || (count == CW'(DIGIT_SLOTS - 1));
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      mag <= load_val;
      dec <= ctl.dec;
    end else if (ctl.step) begin
      mag <= quo;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.step) begin
      store[count[AW-1:0]] <= digit;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctl.load) begin
      count <= '0;
    end else if (ctl.step) begin
      count <= count + CW'(1);
    end
  end

  // write-through when the digit being stored is the one asked for
  always_ff @(posedge clk) begin
    if (ctl.step && (count[AW-1:0] == rd_addr)) begin
      rd_digit <= digit;
    end else begin
      rd_digit <= store[rd_addr];
    end
  end

endmodule

// ===== design/ita_char_out.sv =====
// ----------------------------------------------------------------------------
// ita_char_out
// Output register stage. Holds one character beat and the running count of
// characters emitted.
// ----------------------------------------------------------------------------
module ita_char_out
  import ita_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  ita_char_beat_t beat,
  output logic           beat_ready,
  ita_out_if.source      chars
);

  logic        valid;
  logic [7:0]  code;
  logic        last;
  logic [31:0] total;

  assign beat_ready = !valid || chars.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      total <= 32'd0;
    end else if (beat.valid && beat_ready) begin
      valid <= 1'b1;
      total <= total + 32'd1;
    end else if (chars.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat.valid && beat_ready) begin
      code <= beat.code;
      last <= beat.last;
    end
  end

  assign chars.valid         = valid;
  assign chars.char_code     = code;
  assign chars.last_char     = last;
  assign chars.total_emitted = total;

endmodule

// ===== design/int_to_ascii_formatter_top.sv =====
// ----------------------------------------------------------------------------
// int_to_ascii_formatter_top
// Formats one integer per request as ASCII text, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   item  : request beat (op, value). Taken only when no conversion is busy.
//   chars : one character per beat, last_char on the final one, and the
//           running 32-bit count of characters sent including this one.
//   op 0/1 signed/unsigned decimal, 2/3 hex lower/upper, 4 pointer ("0x"
//   plus hex, "(nil)" for zero). Unknown ops are dropped with no beats.
// Sequence:
//   The request is taken, then the shared divide unit splits off one digit
//   per step (decimal up to 10, hex up to 8, pointer up to 16; none for a
//   zero pointer), then one character per cycle goes into the output
//   register while the receiver keeps up. The next request is taken once
//   the last character has been loaded.
// Reset clears the sequencer, the output register and the running count.
// A stalled receiver holds the output register and pauses emission.
// ----------------------------------------------------------------------------
module int_to_ascii_formatter_top
  import ita_pkg::*;
#(
  parameter int DIGIT_SLOTS = 16
) (
  input  logic      clk,
  input  logic      rst,
  ita_in_if.sink    item,
  ita_out_if.source chars
);

  localparam int AW = (DIGIT_SLOTS > 1) ? $clog2(DIGIT_SLOTS) : 1;
  localparam int CW = $clog2(DIGIT_SLOTS + 1);

  ita_state_t     state, state_next;
  ita_pfx_t       pfx, pfx_next;
  logic [2:0]     pos, pos_next;
  logic [CW-1:0]  dig_left, dig_left_next;
  logic           upper, upper_next;

  ita_unit_ctl_t  ctl;
  logic [63:0]    load_val;
  logic [AW-1:0]  rd_addr;
  logic [3:0]     rd_digit;
  logic [CW-1:0]  unit_count;
  logic           unit_last;
  logic [CW-1:0]  dig_prev;
  logic [CW-1:0]  rd_next;
  logic [31:0]    low;
  logic [2:0]     plen;
  logic           in_pfx;

  ita_char_beat_t emit;
  logic           beat_ready;

  ita_digit_unit #(.DIGIT_SLOTS(DIGIT_SLOTS)) u_unit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .load_val  (load_val),
    .rd_addr   (rd_addr),
    .rd_digit  (rd_digit),
    .count     (unit_count),
    .last_step (unit_last)
  );

  ita_char_out u_out (
    .clk        (clk),
    .rst        (rst),
    .beat       (emit),
    .beat_ready (beat_ready),
    .chars      (chars)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pfx      <= PFX_NONE;
      pos      <= 3'd0;
      dig_left <= '0;
      upper    <= 1'b0;
    end else begin
      state    <= state_next;
      pfx      <= pfx_next;
      pos      <= pos_next;
      dig_left <= dig_left_next;
      upper    <= upper_next;
    end
  end

  always_comb begin
    state_next    = state;
    pfx_next      = pfx;
    pos_next      = pos;
    dig_left_next = dig_left;
    upper_next    = upper;
    ctl           = '0;
    load_val      = 64'd0;
    item.ready    = 1'b0;
    emit          = '0;
    low           = item.value[31:0];
    dig_prev      = dig_left - CW'(1);
    plen          = pfx_len(pfx);
    in_pfx        = pos < plen;

    case (state)
      ST_IDLE: begin
        item.ready = 1'b1;
        if (item.valid) begin
          pos_next   = 3'd0;
          upper_next = (item.op == OP_HEXU);
          case (ita_op_t'(item.op))
            OP_SDEC: begin
              pfx_next   = low[31] ? PFX_MINUS : PFX_NONE;
              ctl.load   = 1'b1;
              ctl.dec    = 1'b1;
              load_val   = {32'd0, low[31] ? (32'd0 - low) : low};
              state_next = ST_CONV;
            end
            OP_UDEC: begin
              pfx_next   = PFX_NONE;
              ctl.load   = 1'b1;
              ctl.dec    = 1'b1;
              load_val   = {32'd0, low};
              state_next = ST_CONV;
            end
            OP_HEXL, OP_HEXU: begin
              pfx_next   = PFX_NONE;
              ctl.load   = 1'b1;
              load_val   = {32'd0, low};
              state_next = ST_CONV;
            end
            OP_PTR: begin
              if (item.value == 64'd0) begin
                pfx_next      = PFX_NIL;
                dig_left_next = '0;
                state_next    = ST_EMIT;
              end else begin
                pfx_next   = PFX_HEX;
                ctl.load   = 1'b1;
                load_val   = item.value;
                state_next = ST_CONV;
              end
            end
            default: state_next = ST_IDLE;
          endcase
        end
      end

      ST_CONV: begin
        ctl.step = 1'b1;
        if (unit_last) begin
          dig_left_next = unit_count + CW'(1);
          state_next    = ST_EMIT;
        end
      end

      ST_EMIT: begin
        emit.valid = 1'b1;
        if (in_pfx) begin
          emit.code = pfx_char(pfx, pos);
          emit.last = (pos == plen - 3'd1) && (dig_left == '0);
        end else begin
          emit.code = digit_char(rd_digit, upper);
          emit.last = (dig_left == CW'(1));
        end
        if (beat_ready) begin
          if (in_pfx) begin
            pos_next = pos + 3'd1;
          end else begin
            dig_left_next = dig_prev;
          end
          if (emit.last) begin
            state_next = ST_IDLE;
          end
        end
      end

      default: state_next = ST_IDLE;
    endcase

    // registered store read: ask for the digit needed next cycle
    rd_next = dig_left_next - CW'(1);
    rd_addr = rd_next[AW-1:0];
  end

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    (item.valid && item.ready && (item.op <= OP_PTR)) |=> (state != ST_IDLE))
    else $error("valid request did not start a conversion");

  a_conv_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_CONV) |-> (unit_count < CW'(DIGIT_SLOTS)))
    else $error("digit count overran the digit store");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && beat_ready && emit.last) |=> (state == ST_IDLE))
    else $error("sequencer kept running after the last character");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (emit.valid && beat_ready)
      |=> (chars.total_emitted == $past(chars.total_emitted) + 32'd1))
    else $error("running count did not advance by one");

  a_emit_has_digit: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EMIT && !in_pfx) |-> (dig_left != '0))
    else $error("digit read with no digits left");

endmodule
